FILE: sv/sliding_window_counter_limiter_macros.svh
// Assertion macros for the sliding window counter limiter
`ifndef SLIDING_WINDOW_COUNTER_LIMITER_MACROS_SVH
`define SLIDING_WINDOW_COUNTER_LIMITER_MACROS_SVH

// same-cycle implication
`define SWCL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swcl assertion failed");

// next-cycle implication
`define SWCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swcl assertion failed");

`endif

FILE: sv/swcl_pkg.sv
// Shared types and constants of the sliding window counter limiter
`default_nettype none
package swcl_pkg;
    localparam int SLOTS_DEF   = 1024;
    localparam int KEY_W       = 10;
    localparam int NOW_W       = 32;
    localparam int CNT_W       = 16;
    localparam int WIN_W       = 12;
    localparam int WAIT_W      = 22;
    localparam int PROD_W      = CNT_W + WIN_W;
    localparam int DIVD_W      = 32;
    localparam int NBIT_W      = 6;
    localparam logic [CNT_W-1:0] LIMIT_RST = 16'd10;
    localparam logic [WIN_W-1:0] WIN_RST   = 12'd60;
    localparam logic REG_LIMIT  = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    typedef enum logic [1:0] {
        DIV_TIME,
        DIV_EST
    } t_div_op;

    typedef struct packed {
        logic    clr_step;
        logic    latch;
        logic    div_go;
        t_div_op div_op;
        logic    mem_rd;
        logic    upd;
        logic    mul;
        logic    fin;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_busy;
    } t_dp_sts;
endpackage
`default_nettype wire

FILE: sv/sliding_window_counter_limiter.sv
// Top level of the sliding window counter rate limiter
// A new transaction is not taken while one is in progress; start is taken again
// in the cycle o_valid is high. The shared bit-serial divider sets the pace: it
// produces 32 quotient bits for the time split and 28 for the estimate.
// After reset a clearing pass over every slot holds busy high; config writes still apply.
`default_nettype none
`include "sliding_window_counter_limiter_macros.svh"
module sliding_window_counter_limiter #(
    parameter int SLOTS = swcl_pkg::SLOTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [swcl_pkg::KEY_W-1:0]    i_key_slot,
    input  wire logic [swcl_pkg::NOW_W-1:0]    i_now_seconds,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [swcl_pkg::CNT_W-1:0]    i_cfg_wdata,
    output logic                               o_valid,
    output logic                               o_allowed,
    output logic      [swcl_pkg::CNT_W-1:0]    o_remaining,
    output logic      [swcl_pkg::WAIT_W-1:0]   o_wait_ms
);
    swcl_pkg::t_dp_cmd cmd;
    swcl_pkg::t_dp_sts sts;

    swcl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    swcl_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_key_slot    (i_key_slot),
        .i_now_seconds (i_now_seconds),
        .o_valid       (o_valid),
        .o_allowed     (o_allowed),
        .o_remaining   (o_remaining),
        .o_wait_ms     (o_wait_ms)
    );

    `SWCL_ASSERT_IMPL(a_result_idle, i_clk, i_rst_n, o_valid, !busy)
    `SWCL_ASSERT_IMPL(a_denied_zero, i_clk, i_rst_n, o_valid && !o_allowed, o_remaining == '0)
endmodule
`default_nettype wire

FILE: sv/swcl_ram.sv
// Generic single-write, single-read RAM with registered read
`default_nettype none
module swcl_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: sv/swcl_div.sv
// Bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module swcl_div #(
    parameter int DW = 17
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_go,
    input  wire logic [swcl_pkg::DIVD_W-1:0]   i_dividend,
    input  wire logic [DW-1:0]                 i_divisor,
    input  wire logic [swcl_pkg::NBIT_W-1:0]   i_nbits,
    output logic                               o_busy,
    output logic      [swcl_pkg::DIVD_W-1:0]   o_quot,
    output logic      [DW-1:0]                 o_rem
);
    logic [swcl_pkg::NBIT_W-1:0] r_cnt;
    logic [DW-1:0]               r_dsr;
    logic [DW:0]                 n_trial;
    logic                        n_ge;

    assign n_trial = {o_rem, o_quot[swcl_pkg::DIVD_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            o_busy <= 1'b1;
            r_cnt  <= i_nbits;
            o_quot <= i_dividend;
            o_rem  <= '0;
            r_dsr  <= i_divisor;
        end else if (o_busy) begin
            o_quot <= {o_quot[swcl_pkg::DIVD_W-2:0], n_ge};
            o_rem  <= n_ge ? DW'(n_trial - {1'b0, r_dsr}) : n_trial[DW-1:0];
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == swcl_pkg::NBIT_W'(1)) begin
                o_busy <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: sv/swcl_dp.sv
// Datapath: configuration, slot table, divider and result registers
`default_nettype none
module swcl_dp #(
    parameter int SLOTS = swcl_pkg::SLOTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire swcl_pkg::t_dp_cmd             i_cmd,
    output swcl_pkg::t_dp_sts                  o_sts,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [swcl_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  wire logic [swcl_pkg::KEY_W-1:0]    i_key_slot,
    input  wire logic [swcl_pkg::NOW_W-1:0]    i_now_seconds,
    output logic                               o_valid,
    output logic                               o_allowed,
    output logic      [swcl_pkg::CNT_W-1:0]    o_remaining,
    output logic      [swcl_pkg::WAIT_W-1:0]   o_wait_ms
);
    localparam int SW  = $clog2(SLOTS);
    localparam int SW1 = $clog2(SLOTS + 1);
    localparam int DW  = swcl_pkg::WIN_W;
    localparam int KW  = (SW > swcl_pkg::KEY_W) ? SW : swcl_pkg::KEY_W;
    localparam int EW  = 1 + swcl_pkg::NOW_W + 2 * swcl_pkg::CNT_W;
    // reciprocal of SLOTS, exact for every key_slot value
    localparam int RS  = swcl_pkg::KEY_W + SW1;
    localparam int PW  = swcl_pkg::KEY_W + RS;
    localparam longint unsigned RM =
        ((64'd1 << RS) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);

    logic [swcl_pkg::CNT_W-1:0]  r_limit;
    logic [swcl_pkg::WIN_W-1:0]  r_wsec;
    logic [swcl_pkg::KEY_W-1:0]  r_key;
    logic [swcl_pkg::KEY_W-1:0]  r_kq;
    logic [swcl_pkg::NOW_W-1:0]  r_now;
    logic [SW-1:0]               r_slot;
    logic [SW-1:0]               r_clr;
    logic [swcl_pkg::NOW_W-1:0]  r_win;
    logic [swcl_pkg::CNT_W-1:0]  r_curr;
    logic [swcl_pkg::CNT_W-1:0]  r_prev;
    logic [swcl_pkg::WIN_W-1:0]  r_ovl;
    logic [swcl_pkg::PROD_W-1:0] r_prod;

    logic [swcl_pkg::WIN_W-1:0]  n_weff;
    logic [KW-1:0]               n_kx;
    logic                        n_key_ok;
    logic [PW-1:0]               n_kprod;
    logic [swcl_pkg::KEY_W-1:0]  n_kmod;
    logic [SW-1:0]               n_slot;
    logic [swcl_pkg::DIVD_W-1:0] n_dvd;
    logic [DW-1:0]               n_dsr;
    logic [swcl_pkg::NBIT_W-1:0] n_nb;
    logic [swcl_pkg::DIVD_W-1:0] n_quot;
    logic [DW-1:0]               n_rem;
    logic                        n_dbusy;
    logic [EW-1:0]               n_rd;
    logic [EW-1:0]               n_wd;
    logic [SW-1:0]               n_wa;
    logic                        n_we;
    logic                        n_e_valid;
    logic [swcl_pkg::NOW_W-1:0]  n_e_win;
    logic [swcl_pkg::CNT_W-1:0]  n_e_curr;
    logic [swcl_pkg::CNT_W-1:0]  n_e_prev;
    logic [swcl_pkg::NOW_W:0]    n_e_win1;
    logic [swcl_pkg::CNT_W:0]    n_est;
    logic                        n_allow;
    logic [swcl_pkg::CNT_W-1:0]  n_curr_inc;

    assign n_weff   = (r_wsec == '0) ? swcl_pkg::WIN_W'(1) : r_wsec;
    assign n_kx     = KW'(r_key);
    assign n_key_ok = 32'(r_key) < 32'(SLOTS);
    assign n_kprod  = PW'(r_key) * PW'(RM);
    assign n_kmod   = r_key - swcl_pkg::KEY_W'(32'(r_kq) * 32'(SLOTS));
    assign n_slot   = n_key_ok ? n_kx[SW-1:0] : SW'(n_kmod);

    assign o_sts.clr_last = r_clr == SW'(SLOTS - 1);
    assign o_sts.div_busy = n_dbusy;

    always_comb begin
        case (i_cmd.div_op)
            swcl_pkg::DIV_TIME: begin
                n_dvd = r_now;
                n_dsr = DW'(n_weff);
                n_nb  = swcl_pkg::NBIT_W'(swcl_pkg::NOW_W);
            end
            swcl_pkg::DIV_EST: begin
                n_dvd = {r_prod, (swcl_pkg::DIVD_W - swcl_pkg::PROD_W)'(0)};
                n_dsr = DW'(n_weff);
                n_nb  = swcl_pkg::NBIT_W'(swcl_pkg::PROD_W);
            end
            default: begin
                n_dvd = r_now;
                n_dsr = DW'(n_weff);
                n_nb  = swcl_pkg::NBIT_W'(swcl_pkg::NOW_W);
            end
        endcase
    end

    swcl_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (n_dvd),
        .i_divisor  (n_dsr),
        .i_nbits    (n_nb),
        .o_busy     (n_dbusy),
        .o_quot     (n_quot),
        .o_rem      (n_rem)
    );

    assign n_e_valid = n_rd[EW-1];
    assign n_e_win   = n_rd[2*swcl_pkg::CNT_W +: swcl_pkg::NOW_W];
    assign n_e_curr  = n_rd[swcl_pkg::CNT_W +: swcl_pkg::CNT_W];
    assign n_e_prev  = n_rd[swcl_pkg::CNT_W-1:0];
    assign n_e_win1  = {1'b0, n_e_win} + 1'b1;

    assign n_est      = {1'b0, r_curr} + {1'b0, n_quot[swcl_pkg::CNT_W-1:0]};
    assign n_allow    = n_est < {1'b0, r_limit};
    assign n_curr_inc = (r_curr < 16'hFFFF) ? r_curr + 1'b1 : r_curr;

    assign n_we = i_cmd.clr_step | (i_cmd.fin & n_allow);
    assign n_wa = i_cmd.clr_step ? r_clr : r_slot;
    assign n_wd = i_cmd.clr_step ? '0 : {1'b1, r_win, n_curr_inc, r_prev};

    swcl_ram #(.W(EW), .D(SLOTS)) u_tab (
        .i_clk   (i_clk),
        .i_we    (n_we | i_cmd.fin),
        .i_waddr (n_wa),
        .i_wdata (i_cmd.fin && !n_allow ? {1'b1, r_win, r_curr, r_prev} : n_wd),
        .i_re    (i_cmd.mem_rd),
        .i_raddr (n_slot),
        .o_rdata (n_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= swcl_pkg::LIMIT_RST;
            r_wsec  <= swcl_pkg::WIN_RST;
            r_clr   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.fin;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    swcl_pkg::REG_LIMIT:  r_limit <= i_cfg_wdata;
                    swcl_pkg::REG_WINDOW: r_wsec  <= i_cfg_wdata[swcl_pkg::WIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kq <= n_kprod[RS +: swcl_pkg::KEY_W];
        if (i_cmd.latch) begin
            r_key <= i_key_slot;
            r_now <= i_now_seconds;
        end
        if (i_cmd.mem_rd) begin
            r_slot <= n_slot;
        end
        if (i_cmd.upd) begin
            r_win <= n_quot;
            r_ovl <= n_weff - n_rem[swcl_pkg::WIN_W-1:0];
            if (!n_e_valid) begin
                r_curr <= '0;
                r_prev <= '0;
            end else if (n_e_win != n_quot) begin
                r_curr <= '0;
                r_prev <= (n_e_win1 == {1'b0, n_quot}) ? n_e_curr : '0;
            end else begin
                r_curr <= n_e_curr;
                r_prev <= n_e_prev;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= r_prev * r_ovl;
        end
        if (i_cmd.fin) begin
            o_allowed   <= n_allow;
            o_remaining <= n_allow ? swcl_pkg::CNT_W'(r_limit - n_est - 1'b1) : '0;
            o_wait_ms   <= n_allow ? '0 :
                           swcl_pkg::WAIT_W'(r_ovl) * swcl_pkg::WAIT_W'(1000);
        end
    end
endmodule
`default_nettype wire

FILE: sv/swcl_ctrl.sv
// Controller state machine sequencing the datapath
`default_nettype none
`include "sliding_window_counter_limiter_macros.svh"
module swcl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire swcl_pkg::t_dp_sts i_sts,
    output swcl_pkg::t_dp_cmd      o_cmd,
    output logic                   o_busy
);
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_KEY,
        S_TGO,
        S_TWAIT,
        S_UPD,
        S_MUL,
        S_EGO,
        S_EWAIT,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_op = swcl_pkg::DIV_TIME;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_KEY;
                end
            end
            // slot reduction settles
            S_KEY: begin
                n_state = S_TGO;
            end
            S_TGO: begin
                o_cmd.div_go = 1'b1;
                o_cmd.mem_rd = 1'b1;
                n_state      = S_TWAIT;
            end
            S_TWAIT: begin
                if (!i_sts.div_busy) n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_EGO;
            end
            S_EGO: begin
                o_cmd.div_go = 1'b1;
                o_cmd.div_op = swcl_pkg::DIV_EST;
                n_state      = S_EWAIT;
            end
            S_EWAIT: begin
                o_cmd.div_op = swcl_pkg::DIV_EST;
                if (!i_sts.div_busy) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            o_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            o_busy  <= n_state != S_IDLE;
        end
    end

    `SWCL_ASSERT_IMPL(a_go_when_free, i_clk, i_rst_n, o_cmd.div_go, !i_sts.div_busy)
    `SWCL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, (r_state == S_IDLE) && i_start, o_busy)
    `SWCL_ASSERT_IMPL(a_clear_busy, i_clk, i_rst_n, r_state == S_CLEAR, o_busy)
endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the sliding window counter rate limiter
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    localparam int NSLOT     = swcl_pkg::SLOTS_DEF;
    localparam int CYC_LIMIT = 600000;

    typedef enum logic {ROW_CFG, ROW_REQ} t_row_kind;

    typedef struct {
        t_row_kind                   kind;
        logic                        idx;
        logic [swcl_pkg::CNT_W-1:0]  wdata;
        logic [swcl_pkg::KEY_W-1:0]  key;
        logic [swcl_pkg::NOW_W-1:0]  now;
        bit                          typed;
        logic                        allowed;
        logic [swcl_pkg::CNT_W-1:0]  remaining;
        logic [swcl_pkg::WAIT_W-1:0] wait_ms;
    } t_row;

    typedef struct packed {
        logic                        allowed;
        logic [swcl_pkg::CNT_W-1:0]  remaining;
        logic [swcl_pkg::WAIT_W-1:0] wait_ms;
    } t_verdict;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [swcl_pkg::KEY_W-1:0]  i_key_slot = '0;
    logic [swcl_pkg::NOW_W-1:0]  i_now_seconds = '0;
    logic                        i_cfg_we = 1'b0;
    logic                        i_cfg_idx = swcl_pkg::REG_LIMIT;
    logic [swcl_pkg::CNT_W-1:0]  i_cfg_wdata = '0;
    logic                        o_valid;
    logic                        o_allowed;
    logic [swcl_pkg::CNT_W-1:0]  o_remaining;
    logic [swcl_pkg::WAIT_W-1:0] o_wait_ms;

    sliding_window_counter_limiter u_top (
        .i_clk, .i_rst_n, .start, .busy, .i_key_slot, .i_now_seconds,
        .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .o_valid, .o_allowed, .o_remaining, .o_wait_ms
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [swcl_pkg::CNT_W-1:0] lim_q = swcl_pkg::LIMIT_RST;
    logic [swcl_pkg::WIN_W-1:0] win_len_q = swcl_pkg::WIN_RST;
    bit                         seen_q [NSLOT];
    logic [31:0]                win_id_q [NSLOT];
    logic [swcl_pkg::CNT_W-1:0] cur_q [NSLOT];
    logic [swcl_pkg::CNT_W-1:0] prev_q [NSLOT];

    t_verdict verdicts_q [$];
    int       n_errors = 0;
    int       cycles = 0;
    int       idle_pct = 0;
    t_row     rows [$];

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        n_errors++;
    endtask

    function automatic t_verdict rate_decision(input logic [swcl_pkg::KEY_W-1:0] key,
                                               input logic [swcl_pkg::NOW_W-1:0] now);
        t_verdict v;
        int unsigned s;
        longint unsigned w, win, el, ov, est;
        s   = key % NSLOT;
        w   = (win_len_q == 0) ? 1 : win_len_q;
        win = now / w;
        el  = now % w;
        ov  = w - el;
        if (!seen_q[s]) begin
            seen_q[s]   = 1'b1;
            win_id_q[s] = win[31:0];
            cur_q[s]    = '0;
            prev_q[s]   = '0;
        end
        if (longint'(win_id_q[s]) != win) begin
            if (longint'(win_id_q[s]) + 1 == win) prev_q[s] = cur_q[s];
            else prev_q[s] = '0;
            cur_q[s]    = '0;
            win_id_q[s] = win[31:0];
        end
        est = cur_q[s] + (longint'(prev_q[s]) * ov) / w;
        if (est < lim_q) begin
            if (cur_q[s] != 16'hFFFF) cur_q[s]++;
            v.allowed   = 1'b1;
            v.remaining = swcl_pkg::CNT_W'(lim_q - est - 1);
            v.wait_ms   = '0;
        end else begin
            v.allowed   = 1'b0;
            v.remaining = '0;
            v.wait_ms   = swcl_pkg::WAIT_W'(ov * 1000);
        end
        return v;
    endfunction

    task automatic wait_idle();
        while (verdicts_q.size() != 0 || busy) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [swcl_pkg::CNT_W-1:0] data);
        start = 1'b0;
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == swcl_pkg::REG_LIMIT) lim_q = data;
        else win_len_q = data[swcl_pkg::WIN_W-1:0];
    endtask

    // returns after the transaction is taken, with start still high
    task automatic send_req(input logic [swcl_pkg::KEY_W-1:0] key,
                            input logic [swcl_pkg::NOW_W-1:0] now,
                            input bit typed, input t_verdict want);
        t_verdict v;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_key_slot    = key;
        i_now_seconds = now;
        start         = 1'b1;
        do @(posedge i_clk); while (busy);
        v = rate_decision(key, now);
        if (typed && v != want)
            report_mismatch($sformatf("table entry disagrees for slot %0d", key));
        verdicts_q.push_back(typed ? want : v);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_verdict e;
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("timeout");
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (verdicts_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = verdicts_q.pop_front();
                if (o_allowed !== e.allowed)
                    report_mismatch($sformatf("allowed %b, want %b", o_allowed, e.allowed));
                if (o_remaining !== e.remaining)
                    report_mismatch($sformatf("remaining %0d, want %0d",
                                              o_remaining, e.remaining));
                if (o_wait_ms !== e.wait_ms)
                    report_mismatch($sformatf("wait_ms %0d, want %0d", o_wait_ms, e.wait_ms));
            end
        end
    end

    function automatic t_row req(input int key, input logic [31:0] now);
        t_row r;
        r = '{ROW_REQ, swcl_pkg::REG_LIMIT, '0, key[swcl_pkg::KEY_W-1:0], now,
              1'b0, 1'b0, '0, '0};
        return r;
    endfunction

    function automatic t_row req_x(input int key, input logic [31:0] now,
                                   input logic a, input int rem, input int wt);
        t_row r;
        r = '{ROW_REQ, swcl_pkg::REG_LIMIT, '0, key[swcl_pkg::KEY_W-1:0], now, 1'b1, a,
              rem[swcl_pkg::CNT_W-1:0], wt[swcl_pkg::WAIT_W-1:0]};
        return r;
    endfunction

    function automatic t_row cfg(input logic idx, input int data);
        t_row r;
        r = '{ROW_CFG, idx, data[swcl_pkg::CNT_W-1:0], '0, '0, 1'b0, 1'b0, '0, '0};
        return r;
    endfunction

    initial begin
        t_verdict                   none;
        logic [swcl_pkg::NOW_W-1:0] clk_s;
        int                         hot [8];
        int                         key;
        logic [swcl_pkg::NOW_W-1:0] now;
        none = '{1'b0, '0, '0};

        rows = '{
            req_x(0, 0, 1'b1, 9, 0),
            req(0, 59),
            req_x(1023, 32'hFFFF_FFFF, 1'b1, 9, 0),
            req(0, 60),
            req(0, 300),
            req(0, 10),
            cfg(swcl_pkg::REG_LIMIT, 0),
            req_x(5, 30, 1'b0, 0, 30000),
            cfg(swcl_pkg::REG_WINDOW, 0),
            cfg(swcl_pkg::REG_LIMIT, 65535),
            req(5, 123),
            req(5, 124),
            cfg(swcl_pkg::REG_WINDOW, 16'hFFFF),
            cfg(swcl_pkg::REG_LIMIT, 2),
            req(7, 32'hFFFF_FFFF),
            req(7, 32'hFFFF_FFFF),
            req(7, 32'hFFFF_FFFF),
            cfg(swcl_pkg::REG_WINDOW, 3600),
            cfg(swcl_pkg::REG_LIMIT, 3),
            req(9, 0), req(9, 1), req(9, 2), req(9, 3),
            req(9, 3600), req(9, 5400)
        };

        for (int i = 0; i < 8; i++) hot[i] = $urandom_range(NSLOT - 1);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].wdata);
            else send_req(rows[i].key, rows[i].now, rows[i].typed,
                          '{rows[i].allowed, rows[i].remaining, rows[i].wait_ms});
        end

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 17 : (ph == 1) ? 87 : 0;
            for (int sub = 0; sub < 4; sub++) begin
                case ($urandom_range(9))
                    0:       write_reg(swcl_pkg::REG_LIMIT, swcl_pkg::CNT_W'(0));
                    1:       write_reg(swcl_pkg::REG_LIMIT,
                                       swcl_pkg::CNT_W'($urandom_range(65535)));
                    default: write_reg(swcl_pkg::REG_LIMIT,
                                       swcl_pkg::CNT_W'($urandom_range(1, 12)));
                endcase
                case ($urandom_range(9))
                    0:       write_reg(swcl_pkg::REG_WINDOW, swcl_pkg::CNT_W'(0));
                    1:       write_reg(swcl_pkg::REG_WINDOW,
                                       swcl_pkg::CNT_W'($urandom_range(65535)));
                    default: write_reg(swcl_pkg::REG_WINDOW,
                                       swcl_pkg::CNT_W'($urandom_range(1, 40)));
                endcase
                clk_s = $urandom;
                for (int n = 0; n < 80; n++) begin
                    key = ($urandom_range(9) < 8) ? hot[$urandom_range(7)]
                                                  : $urandom_range(NSLOT - 1);
                    case ($urandom_range(19))
                        0:       now = $urandom;
                        1:       now = clk_s - $urandom_range(50);
                        default: begin
                            clk_s = clk_s + $urandom_range(0, 3);
                            now   = clk_s;
                        end
                    endcase
                    send_req(key[swcl_pkg::KEY_W-1:0], now, 1'b0, none);
                end
            end
        end

        start = 1'b0;
        wait_idle();
        repeat (100) @(negedge i_clk);
        if (n_errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+sv
sv/swcl_pkg.sv
sv/swcl_ram.sv
sv/swcl_div.sv
sv/swcl_dp.sv
sv/swcl_ctrl.sv
sv/sliding_window_counter_limiter.sv
dv/testbench.sv
